[rtl/psit_pkg.sv]
// ----------------------------------------------------------------------------
// psit_pkg
// types and constants shared by the point sequence intern table
// ----------------------------------------------------------------------------
package psit_pkg;

  localparam int POINT_DEPTH_DEF   = 65536;
  localparam int SHAPE_DEPTH_DEF   = 4096;
  localparam int MAX_SHAPE_LEN_DEF = 64;
  localparam int COORD_BITS_DEF    = 16;

  typedef enum logic [1:0] {
    ACT_POINT = 2'd0,
    ACT_APPLY = 2'd1,
    ACT_DROP  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_FOUND = 2'd0,
    ST_ADDED = 2'd1,
    ST_FULL  = 2'd2,
    ST_LONG  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REC_RD,
    S_REC_WAIT,
    S_REC_CHK,
    S_PT_RD,
    S_PT_WAIT,
    S_PT_CHK,
    S_APPEND,
    S_REC_WR,
    S_OUT
  } state_t;

endpackage

[rtl/point_sequence_intern_table.sv]
// ----------------------------------------------------------------------------
// point_sequence_intern_table
// interns point sequences in a point store and shape table, with commit and
// rollback of the pending counts
// ----------------------------------------------------------------------------
// A shape is sent one point per request; the request with last set closes it.
// Point, apply and drop requests that do not close a shape leave the block idle.
// A closing request starts a walk over the committed shape records in index
// order through one compare unit: each record is read and checked in REC_RD,
// REC_WAIT and REC_CHK, and on a length match its points are compared in
// PT_RD, PT_WAIT and PT_CHK; a full match ends in PT_RD. The walk ends in
// REC_RD; a new shape is then written point by point in APPEND and its record
// in REC_WR. An overlong shape skips the walk, a full store the append. The
// result waits in an output register; no request is taken until accepted.
// ----------------------------------------------------------------------------
module point_sequence_intern_table #(
  parameter int POINT_DEPTH   = psit_pkg::POINT_DEPTH_DEF,
  parameter int SHAPE_DEPTH   = psit_pkg::SHAPE_DEPTH_DEF,
  parameter int MAX_SHAPE_LEN = psit_pkg::MAX_SHAPE_LEN_DEF,
  parameter int COORD_BITS    = psit_pkg::COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic signed [COORD_BITS-1:0] x,
  input  logic signed [COORD_BITS-1:0] y,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [11:0] shape_index,
  output logic [15:0] point_position,
  output logic [6:0]  length
);

  localparam int PA = $clog2(POINT_DEPTH);
  localparam int SA = $clog2(SHAPE_DEPTH);
  localparam int LA = $clog2(MAX_SHAPE_LEN);
  localparam int PW = PA + 1;
  localparam int SW = SA + 1;
  localparam int LW = LA + 1;
  localparam int PTW = 2 * COORD_BITS;
  localparam int RW = PA + LW;

  logic [PTW-1:0] pmem [POINT_DEPTH];
  logic [RW-1:0]  smem [SHAPE_DEPTH];
  logic [PTW-1:0] cmem [MAX_SHAPE_LEN];

  psit_pkg::state_t state, state_next;

  logic [PW-1:0] pcount, cpcount;
  logic [SW-1:0] scount, cscount;
  logic [LW-1:0] clen, len;
  logic          ovf;
  logic [SW-1:0] ri;
  logic [LW-1:0] pi;
  logic [PA-1:0] rpos;
  logic [PTW-1:0] pdat, cdat;
  logic [RW-1:0]  rdat;
  logic [1:0]  o_status;
  logic [SA-1:0] o_idx;
  logic [PA-1:0] o_pos;
  logic [LW-1:0] o_len;

  logic acc, close;
  logic [PW:0] psum;
  logic full;
  logic [LW-1:0] rlen;
  logic [PA-1:0] rstart;
  logic [PA:0]   paddr;

  assign acc   = in_valid && !in_stall;
  assign close = acc && action == psit_pkg::ACT_POINT && last;
  assign rlen  = rdat[LW-1:0];
  assign rstart = rdat[RW-1:LW];
  assign psum  = {1'b0, pcount} + {{(PW-LW+1){1'b0}}, len};
  assign full  = psum > (PW+1)'(POINT_DEPTH) || scount >= SW'(SHAPE_DEPTH);
  assign paddr = {1'b0, rpos} + (PA+1)'(pi);

  always_comb begin
    state_next = state;
    case (state)
      psit_pkg::S_IDLE:     if (close) state_next = psit_pkg::S_REC_RD;
      psit_pkg::S_REC_RD: begin
        if (ovf) state_next = psit_pkg::S_OUT;
        else if (ri >= cscount || ri >= SW'(SHAPE_DEPTH)) begin
          state_next = full ? psit_pkg::S_OUT : psit_pkg::S_APPEND;
        end else state_next = psit_pkg::S_REC_WAIT;
      end
      psit_pkg::S_REC_WAIT: state_next = psit_pkg::S_REC_CHK;
      psit_pkg::S_REC_CHK:
        state_next = (rlen == len) ? psit_pkg::S_PT_RD : psit_pkg::S_REC_RD;
      psit_pkg::S_PT_RD: begin
        if (pi >= len) state_next = psit_pkg::S_OUT;
        else if (paddr >= (PA+1)'(POINT_DEPTH)) state_next = psit_pkg::S_REC_RD;
        else state_next = psit_pkg::S_PT_WAIT;
      end
      psit_pkg::S_PT_WAIT:  state_next = psit_pkg::S_PT_CHK;
      psit_pkg::S_PT_CHK:
        state_next = (pdat == cdat) ? psit_pkg::S_PT_RD : psit_pkg::S_REC_RD;
      psit_pkg::S_APPEND:   if (pi + 1'b1 >= len) state_next = psit_pkg::S_REC_WR;
      psit_pkg::S_REC_WR:   state_next = psit_pkg::S_OUT;
      psit_pkg::S_OUT:      if (!out_stall) state_next = psit_pkg::S_IDLE;
      default:              state_next = psit_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = state != psit_pkg::S_IDLE;
    out_valid = state == psit_pkg::S_OUT;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= psit_pkg::S_IDLE;
    else state <= state_next;
  end

  // counts and candidate
  always_ff @(posedge clk) begin
    if (rst) begin
      pcount <= '0; cpcount <= '0; scount <= '0; cscount <= '0;
      clen <= '0; ovf <= 1'b0;
    end else begin
      if (acc && action == psit_pkg::ACT_APPLY) begin
        cpcount <= pcount; cscount <= scount;
      end
      if (acc && action == psit_pkg::ACT_DROP) begin
        pcount <= cpcount; scount <= cscount;
      end
      if (acc && action == psit_pkg::ACT_POINT) begin
        if (clen < LW'(MAX_SHAPE_LEN)) clen <= clen + 1'b1;
        else ovf <= 1'b1;
        if (last) clen <= '0;
      end
      if (state == psit_pkg::S_REC_RD && ovf) ovf <= 1'b0;
      if (state == psit_pkg::S_REC_WR) begin
        scount <= scount + 1'b1;
        pcount <= psum[PW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && action == psit_pkg::ACT_POINT && clen < LW'(MAX_SHAPE_LEN))
      cmem[clen[LA-1:0]] <= {x, y};
    if (state == psit_pkg::S_APPEND)
      pmem[pcount[PA-1:0] + PA'(pi)] <= cdat;
    if (state == psit_pkg::S_REC_WR)
      smem[scount[SA-1:0]] <= {pcount[PA-1:0], len};
    if (state == psit_pkg::S_REC_RD) rdat <= smem[ri[SA-1:0]];
    if (state == psit_pkg::S_PT_RD) pdat <= pmem[paddr[PA-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state == psit_pkg::S_PT_RD || state == psit_pkg::S_APPEND ||
        state == psit_pkg::S_REC_CHK || state == psit_pkg::S_REC_RD)
      cdat <= cmem[(state == psit_pkg::S_APPEND) ? LA'(pi + 1'b1) :
                   (state == psit_pkg::S_REC_RD) ? LA'(0) : LA'(pi)];
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    case (state)
      psit_pkg::S_IDLE: begin
        ri <= '0;
        pi <= '0;
        if (close) len <= (clen < LW'(MAX_SHAPE_LEN)) ? clen + 1'b1 : clen;
      end
      psit_pkg::S_REC_RD: begin
        pi <= '0;
        if (ovf) begin
          o_status <= psit_pkg::ST_LONG;
          o_idx <= '0; o_pos <= '0; o_len <= '0;
        end else if (ri >= cscount || ri >= SW'(SHAPE_DEPTH)) begin
          o_status <= full ? psit_pkg::ST_FULL : psit_pkg::ST_ADDED;
          o_idx <= full ? '0 : scount[SA-1:0];
          o_pos <= full ? '0 : pcount[PA-1:0];
          o_len <= len;
        end
      end
      psit_pkg::S_REC_CHK: begin
        rpos <= rstart;
        if (rlen != len) ri <= ri + 1'b1;
      end
      psit_pkg::S_PT_RD: begin
        if (pi >= len) begin
          o_status <= psit_pkg::ST_FOUND;
          o_idx <= ri[SA-1:0]; o_pos <= rpos; o_len <= len;
        end else if (paddr >= (PA+1)'(POINT_DEPTH)) ri <= ri + 1'b1;
      end
      psit_pkg::S_PT_CHK: begin
        if (pdat == cdat) pi <= pi + 1'b1;
        else ri <= ri + 1'b1;
      end
      psit_pkg::S_APPEND: pi <= pi + 1'b1;
      default: ;
    endcase
  end

  assign status         = o_status;
  assign shape_index    = 12'(o_idx);
  assign point_position = 16'(o_pos);
  assign length         = 7'(o_len);

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for point_sequence_intern_table. A queue of requests (directed
// shapes, then random shapes drawn partly from a library of earlier shapes,
// with apply, drop and unused requests mixed in) drives the block with random
// gaps. A behavioral intern table predicts each closing result, and a monitor
// compares the results field by field under random and long output stalls.
// Small store sizes are used so that full stores are reached.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int PDEPTH   = 1024;
  localparam int SDEPTH   = 128;
  localparam int MAXLEN   = 64;
  localparam int NITEMS   = 1850;
  localparam int WD_LIMIT = 200000;

  typedef struct packed {
    psit_pkg::action_t act;
    logic [15:0] px;
    logic [15:0] py;
    logic        lst;
  } request_t;

  typedef struct packed {
    psit_pkg::status_t st;
    logic [11:0] idx;
    logic [15:0] pos;
    logic [6:0]  len;
  } intern_result_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  action;
  logic signed [15:0] x;
  logic signed [15:0] y;
  logic        last;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [11:0] shape_index;
  logic [15:0] point_position;
  logic [6:0]  length;

  request_t       pending_reqs[$];
  intern_result_t expected_results[$];

  logic [31:0] store_pts[PDEPTH];
  int          tab_pos[SDEPTH];
  int          tab_len[SDEPTH];
  logic [31:0] cand[MAXLEN];
  int          cand_len;
  bit          cand_ovf;
  int          pt_cnt, pt_cnt_c, sh_cnt, sh_cnt_c;

  logic [31:0] lib_pts[$];
  int          lib_start[$];
  int          lib_len[$];

  int errors;
  int gap;
  int hold;
  int req_done;
  int idle_cycles;
  bit burst;

  point_sequence_intern_table #(
    .POINT_DEPTH(PDEPTH),
    .SHAPE_DEPTH(SDEPTH),
    .MAX_SHAPE_LEN(MAXLEN),
    .COORD_BITS(16)
  ) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .x(x), .y(y), .last(last),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .shape_index(shape_index),
    .point_position(point_position), .length(length)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  task automatic intern_request(input request_t r);
    intern_result_t res;
    int n;
    bit hit;
    case (r.act)
      psit_pkg::ACT_APPLY: begin
        pt_cnt_c = pt_cnt;
        sh_cnt_c = sh_cnt;
      end
      psit_pkg::ACT_DROP: begin
        pt_cnt = pt_cnt_c;
        sh_cnt = sh_cnt_c;
      end
      psit_pkg::ACT_POINT: begin
        if (cand_len < MAXLEN) begin
          cand[cand_len] = {r.px, r.py};
          cand_len++;
        end else begin
          cand_ovf = 1;
        end
        if (r.lst) begin
          n = cand_len;
          cand_len = 0;
          res = '0;
          if (cand_ovf) begin
            cand_ovf = 0;
            res.st = psit_pkg::ST_LONG;
            expected_results.push_back(res);
          end else begin
            for (int i = 0; i < sh_cnt_c; i++) begin
              if (tab_len[i] == n) begin
                hit = 1;
                for (int k = 0; k < n; k++)
                  if (store_pts[tab_pos[i] + k] != cand[k]) hit = 0;
                if (hit) begin
                  res.st  = psit_pkg::ST_FOUND;
                  res.idx = 12'(i);
                  res.pos = 16'(tab_pos[i]);
                  res.len = 7'(n);
                  expected_results.push_back(res);
                  return;
                end
              end
            end
            res.len = 7'(n);
            if (pt_cnt + n > PDEPTH || sh_cnt + 1 > SDEPTH) begin
              res.st = psit_pkg::ST_FULL;
            end else begin
              for (int k = 0; k < n; k++) store_pts[pt_cnt + k] = cand[k];
              tab_pos[sh_cnt] = pt_cnt;
              tab_len[sh_cnt] = n;
              res.st  = psit_pkg::ST_ADDED;
              res.idx = 12'(sh_cnt);
              res.pos = 16'(pt_cnt);
              sh_cnt++;
              pt_cnt += n;
            end
            expected_results.push_back(res);
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
      action   <= psit_pkg::ACT_POINT;
      x        <= '0;
      y        <= '0;
      last     <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        intern_request(pending_reqs.pop_front());
        req_done++;
        if ($urandom_range(0, 199) == 0) burst = !burst;
        gap = pick_gap();
      end
      if (!in_valid || !in_stall) begin
        if (gap > 0) begin
          gap--;
          in_valid <= 0;
        end else if (pending_reqs.size() > 0) begin
          in_valid <= 1;
          action   <= pending_reqs[0].act;
          x        <= pending_reqs[0].px;
          y        <= pending_reqs[0].py;
          last     <= pending_reqs[0].lst;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst) hold <= 0;
    else if (req_done == 400 && hold == 0) hold <= 3000;
    else if (hold > 1) hold <= hold - 1;
  end

  // monitor
  always @(posedge clk) begin
    intern_result_t e;
    if (rst) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result status=%0d", status);
        end else begin
          e = expected_results.pop_front();
          if (status != e.st || shape_index != e.idx || point_position != e.pos ||
              length != e.len) begin
            errors++;
            if (errors <= 10)
              $display("mismatch exp st=%0d idx=%0d pos=%0d len=%0d got %0d %0d %0d %0d",
                       e.st, e.idx, e.pos, e.len, status, shape_index,
                       point_position, length);
          end
        end
      end
      if (hold > 1) out_stall <= 1;
      else if (burst) out_stall <= 0;
      else out_stall <= ($urandom_range(0, 99) < 25) ||
                        ($urandom_range(0, 299) == 0);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WD_LIMIT) begin
      $display("FAIL point_sequence_intern_table");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic void push_req(psit_pkg::action_t a, logic [15:0] px,
                                   logic [15:0] py, logic l);
    request_t r;
    r.act = a;
    r.px  = px;
    r.py  = py;
    r.lst = l;
    pending_reqs.push_back(r);
  endfunction

  function automatic void push_shape(int n, bit from_lib);
    int li;
    logic [31:0] p;
    li = from_lib ? $urandom_range(0, lib_start.size() - 1) : 0;
    if (from_lib) n = lib_len[li];
    else lib_start.push_back(lib_pts.size());
    for (int k = 0; k < n; k++) begin
      if (from_lib) p = lib_pts[lib_start[li] + k];
      else begin
        p = $urandom;
        lib_pts.push_back(p);
      end
      if (from_lib && k == n - 1 && $urandom_range(0, 9) == 0) p[$urandom_range(0, 31)] ^= 1;
      if ($urandom_range(0, 39) == 0)
        push_req($urandom_range(0, 1) ? psit_pkg::ACT_APPLY : psit_pkg::ACT_DROP,
                 16'($urandom), 16'($urandom), 1'($urandom));
      push_req(psit_pkg::ACT_POINT, p[31:16], p[15:0], k == n - 1);
    end
    if (!from_lib) lib_len.push_back(n);
  endfunction

  initial begin
    int r;
    rst = 1;
    errors = 0; gap = 0; req_done = 0; burst = 0;
    cand_len = 0; cand_ovf = 0;
    pt_cnt = 0; pt_cnt_c = 0; sh_cnt = 0; sh_cnt_c = 0;

    // directed
    push_req(psit_pkg::ACT_POINT, 16'h8000, 16'h7fff, 1);
    push_req(psit_pkg::ACT_POINT, 16'h8000, 16'h7fff, 1);
    push_req(psit_pkg::ACT_APPLY, 16'h0, 16'h0, 0);
    push_req(psit_pkg::ACT_POINT, 16'h8000, 16'h7fff, 1);
    push_req(psit_pkg::ACT_POINT, 16'hffff, 16'h0000, 0);
    push_req(psit_pkg::ACT_DROP, 16'hffff, 16'hffff, 1);
    push_req(psit_pkg::ACT_NONE, 16'h1234, 16'h5678, 1);
    push_req(psit_pkg::ACT_POINT, 16'h7fff, 16'h8000, 1);
    push_req(psit_pkg::ACT_POINT, 16'h0000, 16'hffff, 1);
    push_req(psit_pkg::ACT_APPLY, 16'hffff, 16'hffff, 1);
    push_req(psit_pkg::ACT_POINT, 16'hffff, 16'h0000, 0);
    push_req(psit_pkg::ACT_POINT, 16'h7fff, 16'h8000, 1);
    push_req(psit_pkg::ACT_POINT, 16'h0000, 16'hffff, 1);
    push_req(psit_pkg::ACT_DROP, 16'h0, 16'h0, 0);
    push_shape(MAXLEN, 0);
    push_shape(MAXLEN + 2, 0);
    push_req(psit_pkg::ACT_APPLY, 16'h0, 16'h0, 0);

    // random
    while (pending_reqs.size() < NITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 12)
        push_req(psit_pkg::ACT_APPLY, 16'($urandom), 16'($urandom), 1'($urandom));
      else if (r < 18)
        push_req(psit_pkg::ACT_DROP, 16'($urandom), 16'($urandom), 1'($urandom));
      else if (r < 20)
        push_req(psit_pkg::ACT_NONE, 16'($urandom), 16'($urandom), 1'($urandom));
      else if (r < 55 && lib_start.size() > 0) push_shape(0, 1);
      else if (r < 97) push_shape($urandom_range(1, 6), 0);
      else if (r < 99) push_shape($urandom_range(7, MAXLEN), 0);
      else push_shape($urandom_range(MAXLEN + 1, MAXLEN + 4), 0);
    end

    repeat (4) @(posedge clk);
    rst <= 0;
    wait (pending_reqs.size() == 0 && expected_results.size() == 0);
    repeat (500) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0)
      $display("PASS point_sequence_intern_table");
    else
      $display("FAIL point_sequence_intern_table");
    $finish;
  end
endmodule
